// ----- rtl/core/b32s_pkg.sv -----
// b32s_pkg: shared types, constants and functions for the segwit address decoder
// holds the polymod step, charset lookup and controller/datapath command structs
// depends on nothing
package b32s_pkg;

  // status codes, also used for the sticky error register
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_BASE58  = 2'd2;

  localparam int          VC_W          = 7;
  localparam logic [6:0]  VC_SAT        = 7'd127;
  localparam int          DELAY_DEPTH   = 6;
  localparam logic [29:0] BECH32_CONST  = 30'h0000001;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
  localparam logic [7:0]  CAP_RESET     = 8'd34;

  localparam logic [7:0] OP_V0    = 8'h00;
  localparam logic [7:0] OP_V1    = 8'h51;
  localparam logic [7:0] PUSH_20  = 8'h14;
  localparam logic [7:0] PUSH_32  = 8'h20;
  localparam logic [5:0] LEN_WPKH = 6'd22;
  localparam logic [5:0] LEN_32   = 6'd34;

  localparam logic [29:0] GEN0 = 30'h3b6a57b2;
  localparam logic [29:0] GEN1 = 30'h26508e6d;
  localparam logic [29:0] GEN2 = 30'h1ea119fa;
  localparam logic [29:0] GEN3 = 30'h3d4233dd;
  localparam logic [29:0] GEN4 = 30'h2a1462b3;

  typedef enum logic [1:0] {
    SEL_HEAD0,
    SEL_HEAD1,
    SEL_PROG,
    SEL_ERR
  } out_sel_t;

  typedef struct packed {
    logic       take;
    logic       eval;
    logic       load_out;
    out_sel_t   out_sel;
    logic       last;
    logic [5:0] idx_next;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [5:0] len;
  } dp_sts_t;

  // one bch polymod step over gf(32)
  function automatic logic [29:0] pm_step(input logic [29:0] acc, input logic [4:0] v);
    logic [29:0] r;
    r = {acc[24:0], v};
    if (acc[25]) r = r ^ GEN0;
    if (acc[26]) r = r ^ GEN1;
    if (acc[27]) r = r ^ GEN2;
    if (acc[28]) r = r ^ GEN3;
    if (acc[29]) r = r ^ GEN4;
    return r;
  endfunction

  // accumulator after the expanded "bc" prefix 3 3 0 2 3, from the start value 1
  localparam logic [29:0] PREFIX_ACC =
    pm_step(pm_step(pm_step(pm_step(pm_step(30'd1, 5'd3), 5'd3), 5'd0), 5'd2), 5'd3);

  // charset lookup: bit 5 is hit, bits 4:0 the value
  function automatic logic [5:0] charset_lookup(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      "q": r = {1'b1, 5'd0};
      "p": r = {1'b1, 5'd1};
      "z": r = {1'b1, 5'd2};
      "r": r = {1'b1, 5'd3};
      "y": r = {1'b1, 5'd4};
      "9": r = {1'b1, 5'd5};
      "x": r = {1'b1, 5'd6};
      "8": r = {1'b1, 5'd7};
      "g": r = {1'b1, 5'd8};
      "f": r = {1'b1, 5'd9};
      "2": r = {1'b1, 5'd10};
      "t": r = {1'b1, 5'd11};
      "v": r = {1'b1, 5'd12};
      "d": r = {1'b1, 5'd13};
      "w": r = {1'b1, 5'd14};
      "0": r = {1'b1, 5'd15};
      "s": r = {1'b1, 5'd16};
      "3": r = {1'b1, 5'd17};
      "j": r = {1'b1, 5'd18};
      "n": r = {1'b1, 5'd19};
      "5": r = {1'b1, 5'd20};
      "4": r = {1'b1, 5'd21};
      "k": r = {1'b1, 5'd22};
      "h": r = {1'b1, 5'd23};
      "c": r = {1'b1, 5'd24};
      "e": r = {1'b1, 5'd25};
      "6": r = {1'b1, 5'd26};
      "m": r = {1'b1, 5'd27};
      "u": r = {1'b1, 5'd28};
      "a": r = {1'b1, 5'd29};
      "7": r = {1'b1, 5'd30};
      "l": r = {1'b1, 5'd31};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/b32s_ctrl.sv -----
// b32s_ctrl: sequencer for the address decoder
// steps char intake, verdict and script beat emission; drives b32s_dp through dp_cmd_t
// depends on b32s_pkg
module b32s_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  input  logic              is_last,
  output logic              char_ready,
  output b32s_pkg::dp_cmd_t cmd,
  input  b32s_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IN,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t     state;
  logic [5:0] k;
  logic       final_beat;

  assign char_ready = (state == S_IN);
  assign final_beat = (sts.len == 6'd0) || (k == sts.len - 6'd1);

  always_comb begin
    cmd          = '0;
    cmd.out_sel  = b32s_pkg::SEL_ERR;
    cmd.take     = char_valid && (state == S_IN);
    cmd.eval     = (state == S_EVAL);
    cmd.load_out = (state == S_EMIT) && sts.out_free;
    cmd.last     = final_beat;
    if (sts.len == 6'd0) begin
      cmd.out_sel = b32s_pkg::SEL_ERR;
    end else if (k == 6'd0) begin
      cmd.out_sel = b32s_pkg::SEL_HEAD0;
    end else if (k == 6'd1) begin
      cmd.out_sel = b32s_pkg::SEL_HEAD1;
    end else begin
      cmd.out_sel = b32s_pkg::SEL_PROG;
    end
    // program read runs one beat ahead of the output register
    cmd.idx_next = cmd.load_out ? (k + 6'd1) : k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      k     <= 6'd0;
    end else begin
      unique case (state)
        S_IN: begin
          if (char_valid && is_last) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_EMIT;
          k     <= 6'd0;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            k <= k + 6'd1;
            if (final_beat) begin
              state <= S_IN;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_eval_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |=> state == S_EMIT)
    else $error("verdict cycle not followed by emission");
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && sts.len != 6'd0) |-> k < sts.len)
    else $error("beat index past script length");
  a_no_take_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.load_out && !cmd.eval)
    else $error("char taken while verdict or emission active");
`endif

endmodule

// ----- rtl/core/b32s_dp.sv -----
// b32s_dp: datapath of the address decoder
// char checks, polymod, value delay, 5-to-8 bit regrouper, program memory, output register
// depends on b32s_pkg
module b32s_dp #(
  parameter int MAX_ADDR_CHARS    = 127,
  parameter int MAX_PROGRAM_BYTES = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  b32s_pkg::dp_cmd_t cmd,
  output b32s_pkg::dp_sts_t sts,
  input  logic [7:0]        addr_char,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              byte_valid,
  input  logic              byte_ready,
  output logic [7:0]        script_byte,
  output logic [5:0]        script_length,
  output logic [1:0]        status,
  output logic              last_byte
);

  localparam int CPW = $clog2(MAX_ADDR_CHARS + 1);
  localparam int PCW = $clog2(MAX_PROGRAM_BYTES + 1);
  localparam int AW  = $clog2(MAX_PROGRAM_BYTES);

  logic [7:0]  out_capacity;
  logic [CPW-1:0] char_position, char_position_next;
  logic [1:0]  error_seen, error_seen_next;
  logic [29:0] checksum_acc, checksum_acc_next;
  logic [6:0]  value_count, value_count_next;
  logic [4:0]  witness_version, witness_version_next;
  logic [4:0]  value_delay [b32s_pkg::DELAY_DEPTH];
  logic [4:0]  value_delay_next [b32s_pkg::DELAY_DEPTH];
  logic [11:0] bit_accumulator, bit_accumulator_next;
  logic [2:0]  pending_bits, pending_bits_next;
  logic [PCW-1:0] program_count, program_count_next;

  logic [7:0]  prog_mem [MAX_PROGRAM_BYTES];
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [AW-1:0] rd_addr;
  logic [7:0]  rd_q;

  logic [7:0]  c_low;
  logic [5:0]  lookup;
  logic [11:0] acc12;
  logic [3:0]  bits;

  logic [5:0]  len_q;
  logic [7:0]  head0_q, head1_q;
  logic [1:0]  code_q;

  logic [29:0] want;
  logic        pad_ok, check_ok, fits;
  logic [5:0]  len_c;
  logic [7:0]  head0_c, head1_c;

  assign c_low  = (addr_char >= "A" && addr_char <= "Z") ? (addr_char + 8'd32) : addr_char;
  assign lookup = b32s_pkg::charset_lookup(c_low);

  always_comb begin
    char_position_next   = char_position;
    error_seen_next      = error_seen;
    checksum_acc_next    = checksum_acc;
    value_count_next     = value_count;
    witness_version_next = witness_version;
    value_delay_next     = value_delay;
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    program_count_next   = program_count;
    mem_we               = 1'b0;
    acc12                = {bit_accumulator[6:0], value_delay[0]};
    bits                 = {1'b0, pending_bits} + 4'd5;
    mem_wdata            = 8'(acc12 >> bits);
    if (cmd.eval) begin
      char_position_next   = '0;
      error_seen_next      = b32s_pkg::STATUS_OK;
      checksum_acc_next    = 30'd1;
      value_count_next     = '0;
      witness_version_next = '0;
      for (int i = 0; i < b32s_pkg::DELAY_DEPTH; i++) value_delay_next[i] = '0;
      bit_accumulator_next = '0;
      pending_bits_next    = '0;
      program_count_next   = '0;
    end else if (cmd.take && char_position < CPW'(MAX_ADDR_CHARS)) begin
      char_position_next = char_position + CPW'(1);
      if (error_seen == b32s_pkg::STATUS_OK) begin
        if (char_position == CPW'(0)) begin
          if (c_low == "1" || c_low == "3") begin
            error_seen_next = b32s_pkg::STATUS_BASE58;
          end else if (c_low != "b") begin
            error_seen_next = b32s_pkg::STATUS_INVALID;
          end
        end else if (char_position == CPW'(1)) begin
          if (c_low != "c") error_seen_next = b32s_pkg::STATUS_INVALID;
        end else if (char_position == CPW'(2)) begin
          if (c_low != "1") begin
            error_seen_next = b32s_pkg::STATUS_INVALID;
          end else begin
            checksum_acc_next = b32s_pkg::PREFIX_ACC;
          end
        end else if (!lookup[5]) begin
          error_seen_next = b32s_pkg::STATUS_INVALID;
        end else begin
          checksum_acc_next = b32s_pkg::pm_step(checksum_acc, lookup[4:0]);
          if (value_count == 7'd0) begin
            witness_version_next = lookup[4:0];
          end else begin
            if (value_count >= 7'd7) begin
              if (bits >= 4'd8) begin
                bits = bits - 4'd8;
                mem_wdata = 8'(acc12 >> bits);
                if (program_count >= PCW'(MAX_PROGRAM_BYTES)) begin
                  error_seen_next = b32s_pkg::STATUS_INVALID;
                end else begin
                  mem_we             = 1'b1;
                  program_count_next = program_count + PCW'(1);
                end
              end
              bit_accumulator_next = acc12;
              pending_bits_next    = bits[2:0];
            end
            for (int i = 0; i < b32s_pkg::DELAY_DEPTH - 1; i++) begin
              value_delay_next[i] = value_delay[i+1];
            end
            value_delay_next[b32s_pkg::DELAY_DEPTH-1] = lookup[4:0];
          end
          if (value_count < b32s_pkg::VC_SAT) value_count_next = value_count + 7'd1;
        end
      end
    end
  end

  // verdict on the state left by the last char
  always_comb begin
    want     = (witness_version == 5'd0) ? b32s_pkg::BECH32_CONST : b32s_pkg::BECH32M_CONST;
    pad_ok   = (pending_bits < 3'd5) &&
               ((bit_accumulator[7:0] & ((8'd1 << pending_bits) - 8'd1)) == 8'd0);
    check_ok = (error_seen == b32s_pkg::STATUS_OK) && (char_position >= CPW'(3)) &&
               (value_count >= 7'd8) && (checksum_acc == want) && pad_ok;
    len_c    = 6'd0;
    head0_c  = b32s_pkg::OP_V0;
    head1_c  = b32s_pkg::PUSH_20;
    if (check_ok) begin
      if (witness_version == 5'd0 && program_count == PCW'(20)) begin
        len_c = b32s_pkg::LEN_WPKH;
      end else if (witness_version == 5'd0 && program_count == PCW'(32)) begin
        len_c   = b32s_pkg::LEN_32;
        head1_c = b32s_pkg::PUSH_32;
      end else if (witness_version == 5'd1 && program_count == PCW'(32)) begin
        len_c   = b32s_pkg::LEN_32;
        head0_c = b32s_pkg::OP_V1;
        head1_c = b32s_pkg::PUSH_32;
      end
    end
    fits = (len_c != 6'd0) && ({2'b00, len_c} <= out_capacity);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity    <= b32s_pkg::CAP_RESET;
      char_position   <= '0;
      error_seen      <= b32s_pkg::STATUS_OK;
      checksum_acc    <= 30'd1;
      value_count     <= '0;
      witness_version <= '0;
      for (int i = 0; i < b32s_pkg::DELAY_DEPTH; i++) value_delay[i] <= '0;
      bit_accumulator <= '0;
      pending_bits    <= '0;
      program_count   <= '0;
      len_q           <= '0;
      code_q          <= b32s_pkg::STATUS_OK;
      byte_valid      <= 1'b0;
    end else begin
      if (cfg_we) out_capacity <= cfg_wdata;
      char_position   <= char_position_next;
      error_seen      <= error_seen_next;
      checksum_acc    <= checksum_acc_next;
      value_count     <= value_count_next;
      witness_version <= witness_version_next;
      value_delay     <= value_delay_next;
      bit_accumulator <= bit_accumulator_next;
      pending_bits    <= pending_bits_next;
      program_count   <= program_count_next;
      if (cmd.eval) begin
        if (error_seen == b32s_pkg::STATUS_BASE58) begin
          len_q  <= 6'd0;
          code_q <= b32s_pkg::STATUS_BASE58;
        end else if (fits) begin
          len_q  <= len_c;
          code_q <= b32s_pkg::STATUS_OK;
        end else begin
          len_q  <= 6'd0;
          code_q <= b32s_pkg::STATUS_INVALID;
        end
      end
      if (cmd.load_out) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      head0_q <= head0_c;
      head1_q <= head1_c;
    end
    if (cmd.load_out) begin
      last_byte     <= cmd.last;
      script_length <= len_q;
      case (cmd.out_sel)
        b32s_pkg::SEL_HEAD0: begin
          script_byte <= head0_q;
          status      <= b32s_pkg::STATUS_OK;
        end
        b32s_pkg::SEL_HEAD1: begin
          script_byte <= head1_q;
          status      <= b32s_pkg::STATUS_OK;
        end
        b32s_pkg::SEL_PROG: begin
          script_byte <= rd_q;
          status      <= b32s_pkg::STATUS_OK;
        end
        default: begin
          script_byte <= 8'd0;
          status      <= code_q;
        end
      endcase
    end
  end

  // program byte store, one write and one registered read per cycle
  assign rd_addr = AW'(cmd.idx_next - 6'd2);

  always_ff @(posedge clk) begin
    if (mem_we) prog_mem[program_count[AW-1:0]] <= mem_wdata;
    rd_q <= prog_mem[rd_addr];
  end

  assign sts = '{out_free: (!byte_valid || byte_ready), len: len_q};

`ifndef SYNTHESIS
  a_clear_after_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> (char_position == '0 && checksum_acc == 30'd1 && program_count == '0))
    else $error("address state not cleared after verdict");
  a_error_beat_shape: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && status != b32s_pkg::STATUS_OK) |->
      (last_byte && script_length == 6'd0 && script_byte == 8'd0))
    else $error("error beat with payload");
  a_prog_count_bound: assert property (@(posedge clk) disable iff (rst)
    program_count <= PCW'(MAX_PROGRAM_BYTES))
    else $error("program count past store depth");
`endif

endmodule

// ----- rtl/core/bech32_address_to_script_core.sv -----
// bech32_address_to_script_core: segwit mainnet address to output script, top level
// joins the sequencer b32s_ctrl and the datapath b32s_dp
// depends on b32s_pkg, b32s_ctrl, b32s_dp
//
//  channel   handshake                payload
//  -------   ---------------------    -------------------------------------------
//  char in   char_valid/char_ready    addr_char, is_last
//  script    byte_valid/byte_ready    script_byte, script_length, status, last_byte
//  config    cfg_we                   cfg_wdata (out_capacity, reset 34)
//
//  one char beat per cycle while the address streams in (polymod step per data-part char)
//  after the last char: a verdict step, then one script beat per cycle unless byte_ready
//  stalls, 22 or 34 beats, or a single error beat; char_ready is low over that burst
//  a stalled byte_ready holds the output register and freezes the burst
//  sync reset clears all control state; the program byte store is not cleared
module bech32_address_to_script_core #(
  parameter int MAX_ADDR_CHARS    = 127,
  parameter int MAX_PROGRAM_BYTES = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] addr_char,
  input  logic       is_last,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] script_byte,
  output logic [5:0] script_length,
  output logic [1:0] status,
  output logic       last_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // command and status between sequencer and datapath
  b32s_pkg::dp_cmd_t cmd;
  b32s_pkg::dp_sts_t sts;

  // sequencer: intake, verdict, emission
  b32s_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .is_last    (is_last),
    .char_ready (char_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath: checks, checksum, regrouper, byte store, output register
  b32s_dp #(
    .MAX_ADDR_CHARS    (MAX_ADDR_CHARS),
    .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .addr_char     (addr_char),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .script_byte   (script_byte),
    .script_length (script_length),
    .status        (status),
    .last_byte     (last_byte)
  );

endmodule

// ----- verif/bech32_address_to_script_core_tb.sv -----
`timescale 1ns / 1ps
// bech32_address_to_script_core_tb: self-checking bench for the segwit address to script core
// builds addresses on the fly, predicts every script beat and checks it; needs b32s_pkg
module bech32_address_to_script_core_tb;

  // decoder limits and code constants kept local to the bench
  localparam int          ADDR_CHAR_LIMIT = 127;
  localparam int          PROG_BYTE_LIMIT = 40;
  localparam logic [29:0] SUM_BECH32      = 30'h0000001;
  localparam logic [29:0] SUM_BECH32M     = 30'h2bc830a3;
  localparam logic [29:0] BCH_GEN [0:4]   = '{30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa,
                                              30'h3d4233dd, 30'h2a1462b3};
  // "bc" expanded: high parts 3 3, separator 0, low parts 2 3
  localparam logic [24:0] HRP_EXP         = {5'd3, 5'd3, 5'd0, 5'd2, 5'd3};
  localparam logic [255:0] ALPHABET       = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [31:0] NOT_IN_SET      = "bio1";

  // run shape
  localparam int RAND_BUDGET     = 105;
  localparam int BUDGET_SLACK    = 25;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 40;
  localparam int N_PLAN          = 7;
  localparam logic [7:0] CAP_PLAN [0:N_PLAN-1] = '{8'd255, 8'd22, 8'd0, 8'd33, 8'd21,
                                                    8'd34, 8'd255};

  typedef enum int {
    AK_WPKH, AK_WSH, AK_TR, AK_ODD_VER, AK_RAW, AK_BROKEN, AK_NOISE, AK_BASE58, AK_COUNT
  } addr_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] length;
    logic [1:0] code;
    logic       tail;
  } script_beat_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic [1:0] code;
  } char_row_t;

  // dut ports, all inputs known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] addr_char = 8'd0;
  logic       is_last = 1'b0;
  logic       byte_valid;
  logic       byte_ready = 1'b0;
  logic [7:0] script_byte;
  logic [5:0] script_length;
  logic [1:0] status;
  logic       last_byte;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  bech32_address_to_script_core dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .addr_char    (addr_char),
    .is_last      (is_last),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .script_byte  (script_byte),
    .script_length(script_length),
    .status       (status),
    .last_byte    (last_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow decoder state, one address at a time
  int          d_pos;
  logic [1:0]  d_err;
  logic [29:0] d_sum;
  int          d_vcount;
  logic [4:0]  d_ver;
  logic [4:0]  d_delay [0:5];
  logic [11:0] d_bits;
  int          d_nbits;
  logic [7:0]  d_prog [0:PROG_BYTE_LIMIT-1];
  int          d_pcount;
  logic [7:0]  d_cap = b32s_pkg::CAP_RESET;

  script_beat_t fresh_beats [$];   // beats of the address just closed
  script_beat_t scripts_due [$];   // beats still owed by the dut
  logic [7:0]   addr_text [$];     // address being sent
  logic [4:0]   addr_vals [$];     // data part values before the checksum

  // bookkeeping
  int  mismatches = 0;
  int  beats_checked = 0;
  int  chars_sent = 0;
  int  live_chars = 0;
  int  addresses = 0;
  int  cap_writes = 0;
  int  n_wpkh = 0, n_wide = 0, n_bad = 0, n_b58 = 0;
  int  held_cycles = 0;
  int  quiet = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  // directed table: edge chars, base58 lead chars, short and malformed prefixes
  char_row_t dir_tab [0:22] = '{
    '{"1",   1'b1, b32s_pkg::STATUS_BASE58},
    '{"3",   1'b0, b32s_pkg::STATUS_OK},
    '{8'hff, 1'b0, b32s_pkg::STATUS_OK},
    '{8'h00, 1'b0, b32s_pkg::STATUS_OK},
    '{"Q",   1'b1, b32s_pkg::STATUS_BASE58},
    '{"b",   1'b1, b32s_pkg::STATUS_INVALID},
    '{"b",   1'b0, b32s_pkg::STATUS_OK},
    '{"c",   1'b0, b32s_pkg::STATUS_OK},
    '{"1",   1'b1, b32s_pkg::STATUS_INVALID},
    '{8'h00, 1'b1, b32s_pkg::STATUS_INVALID},
    '{8'hff, 1'b1, b32s_pkg::STATUS_INVALID},
    '{"B",   1'b0, b32s_pkg::STATUS_OK},
    '{"c",   1'b0, b32s_pkg::STATUS_OK},
    '{"1",   1'b0, b32s_pkg::STATUS_OK},
    '{"q",   1'b0, b32s_pkg::STATUS_OK},
    '{"q",   1'b0, b32s_pkg::STATUS_OK},
    '{"q",   1'b0, b32s_pkg::STATUS_OK},
    '{"Q",   1'b1, b32s_pkg::STATUS_INVALID},
    '{"b",   1'b0, b32s_pkg::STATUS_OK},
    '{"x",   1'b1, b32s_pkg::STATUS_INVALID},
    '{"B",   1'b0, b32s_pkg::STATUS_OK},
    '{"C",   1'b0, b32s_pkg::STATUS_OK},
    '{"2",   1'b1, b32s_pkg::STATUS_INVALID}
  };

  // gf(32) bch step over the 30-bit checksum register
  function automatic logic [29:0] bch_mix(input logic [29:0] acc, input logic [4:0] v);
    logic [29:0] r;
    int k;
    r = {acc[24:0], v};
    for (k = 0; k < 5; k++) begin
      if (acc[25 + k]) r = r ^ BCH_GEN[k];
    end
    return r;
  endfunction

  function automatic logic [7:0] alpha(input int v);
    return ALPHABET[8 * (31 - v) +: 8];
  endfunction

  function automatic int value_of(input logic [7:0] c);
    int k;
    for (k = 0; k < 32; k++) begin
      if (alpha(k) == c) return k;
    end
    return -1;
  endfunction

  function automatic void clear_decoder();
    int k;
    d_pos = 0;
    d_err = b32s_pkg::STATUS_OK;
    d_sum = 30'd1;
    d_vcount = 0;
    d_ver = 5'd0;
    for (k = 0; k < 6; k++) d_delay[k] = 5'd0;
    d_bits = 12'd0;
    d_nbits = 0;
    d_pcount = 0;
  endfunction

  // 5-bit to 8-bit regrouping of one program value
  function automatic void regroup(input logic [4:0] v);
    logic [11:0] a;
    int bits;
    a = {d_bits[6:0], v};
    bits = d_nbits + 5;
    if (bits >= 8) begin
      bits = bits - 8;
      if (d_pcount >= PROG_BYTE_LIMIT) begin
        if (d_err == b32s_pkg::STATUS_OK) d_err = b32s_pkg::STATUS_INVALID;
      end else begin
        d_prog[d_pcount] = 8'(a >> bits);
        d_pcount++;
      end
    end
    d_bits = a;
    d_nbits = bits & 7;
  endfunction

  function automatic void absorb_char(input logic [7:0] raw);
    logic [7:0] c;
    int p;
    int v;
    int k;
    if (d_pos >= ADDR_CHAR_LIMIT) return;
    p = d_pos;
    d_pos = d_pos + 1;
    if (d_err != b32s_pkg::STATUS_OK) return;
    c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
    if (p == 0) begin
      if (c == "1" || c == "3") d_err = b32s_pkg::STATUS_BASE58;
      else if (c != "b") d_err = b32s_pkg::STATUS_INVALID;
    end else if (p == 1) begin
      if (c != "c") d_err = b32s_pkg::STATUS_INVALID;
    end else if (p == 2) begin
      if (c != "1") begin
        d_err = b32s_pkg::STATUS_INVALID;
      end else begin
        for (k = 0; k < 5; k++) d_sum = bch_mix(d_sum, HRP_EXP[5 * (4 - k) +: 5]);
      end
    end else begin
      v = value_of(c);
      if (v < 0) begin
        d_err = b32s_pkg::STATUS_INVALID;
      end else begin
        d_sum = bch_mix(d_sum, v[4:0]);
        if (d_vcount == 0) begin
          d_ver = v[4:0];
        end else begin
          // six-deep delay keeps the checksum values out of the program
          if (d_vcount >= 7) regroup(d_delay[0]);
          for (k = 0; k < 5; k++) d_delay[k] = d_delay[k + 1];
          d_delay[5] = v[4:0];
        end
        if (d_vcount < 127) d_vcount++;
      end
    end
  endfunction

  // verdict on the last char: script beats or one error beat
  function automatic void close_address();
    logic [29:0] want;
    logic [5:0]  len;
    logic [7:0]  h0, h1, b;
    int k;
    fresh_beats = {};
    if (d_err == b32s_pkg::STATUS_BASE58) begin
      fresh_beats.push_back('{8'd0, 6'd0, b32s_pkg::STATUS_BASE58, 1'b1});
      n_b58++;
    end else begin
      want = (d_ver == 5'd0) ? SUM_BECH32 : SUM_BECH32M;
      len = 6'd0;
      h0 = 8'd0;
      h1 = 8'd0;
      if (d_err == b32s_pkg::STATUS_OK && d_pos >= 3 && d_vcount >= 8 && d_sum == want &&
          d_nbits < 5 && (d_bits & 12'((1 << d_nbits) - 1)) == 12'd0) begin
        if (d_ver == 5'd0 && d_pcount == 20) begin
          len = b32s_pkg::LEN_WPKH; h0 = b32s_pkg::OP_V0; h1 = b32s_pkg::PUSH_20;
        end else if (d_ver == 5'd0 && d_pcount == 32) begin
          len = b32s_pkg::LEN_32; h0 = b32s_pkg::OP_V0; h1 = b32s_pkg::PUSH_32;
        end else if (d_ver == 5'd1 && d_pcount == 32) begin
          len = b32s_pkg::LEN_32; h0 = b32s_pkg::OP_V1; h1 = b32s_pkg::PUSH_32;
        end
      end
      if (len == 6'd0 || d_cap < 8'(len)) begin
        fresh_beats.push_back('{8'd0, 6'd0, b32s_pkg::STATUS_INVALID, 1'b1});
        n_bad++;
      end else begin
        for (k = 0; k < int'(len); k++) begin
          b = (k == 0) ? h0 : (k == 1) ? h1 : d_prog[k - 2];
          fresh_beats.push_back('{b, len, b32s_pkg::STATUS_OK, (k + 1 == int'(len))});
        end
        if (len == b32s_pkg::LEN_WPKH) n_wpkh++;
        else n_wide++;
      end
    end
    clear_decoder();
  endfunction

  // random program bytes regrouped to 5-bit values with zero padding
  function automatic void pack_program(input int nbytes);
    logic [11:0] a;
    int bits;
    int k;
    a = 12'd0;
    bits = 0;
    addr_vals = {};
    for (k = 0; k < nbytes; k++) begin
      a = {a[3:0], 8'($urandom_range(0, 255))};
      bits = bits + 8;
      while (bits >= 5) begin
        bits = bits - 5;
        addr_vals.push_back(5'(a >> bits));
      end
    end
    if (bits > 0) addr_vals.push_back(5'(a << (5 - bits)));
  endfunction

  // "bc1" + version + values + six checksum chars
  function automatic void wrap_address(input logic [4:0] ver, input logic [29:0] konst);
    logic [29:0] s;
    int k;
    s = 30'd1;
    for (k = 0; k < 5; k++) s = bch_mix(s, HRP_EXP[5 * (4 - k) +: 5]);
    s = bch_mix(s, ver);
    for (k = 0; k < addr_vals.size(); k++) s = bch_mix(s, addr_vals[k]);
    for (k = 0; k < 6; k++) s = bch_mix(s, 5'd0);
    s = s ^ konst;
    addr_text = {};
    addr_text.push_back("b");
    addr_text.push_back("c");
    addr_text.push_back("1");
    addr_text.push_back(alpha(ver));
    for (k = 0; k < addr_vals.size(); k++) addr_text.push_back(alpha(addr_vals[k]));
    for (k = 0; k < 6; k++) addr_text.push_back(alpha(int'((s >> (5 * (5 - k))) & 30'h1f)));
  endfunction

  function automatic void make_address(input addr_kind_t kind);
    logic [4:0]  ver;
    logic [29:0] konst;
    int n, k, idx, mode;
    case (kind)
      AK_WPKH: begin
        pack_program(20);
        wrap_address(5'd0, SUM_BECH32);
      end
      AK_WSH: begin
        pack_program(32);
        wrap_address(5'd0, SUM_BECH32);
      end
      AK_TR: begin
        pack_program(32);
        wrap_address(5'd1, SUM_BECH32M);
      end
      AK_ODD_VER: begin
        // any version and length, right constant most of the time
        ver = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
        konst = (ver == 5'd0) ? SUM_BECH32 : SUM_BECH32M;
        if ($urandom_range(0, 3) == 0) konst = (konst == SUM_BECH32) ? SUM_BECH32M : SUM_BECH32;
        pack_program($urandom_range(0, 42));
        wrap_address(ver, konst);
      end
      AK_RAW: begin
        // raw values: padding faults, program overflow, overlong addresses
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(66, 128) : $urandom_range(0, 70);
        addr_vals = {};
        for (k = 0; k < n; k++) addr_vals.push_back(5'($urandom_range(0, 31)));
        ver = 5'($urandom_range(0, 1));
        wrap_address(ver, (ver == 5'd0) ? SUM_BECH32 : SUM_BECH32M);
      end
      AK_BROKEN: begin
        if ($urandom_range(0, 1) == 0) begin
          pack_program(20);
          wrap_address(5'd0, SUM_BECH32);
        end else begin
          pack_program(32);
          wrap_address(5'd1, SUM_BECH32M);
        end
        mode = $urandom_range(0, 3);
        idx = $urandom_range(3, addr_text.size() - 1);
        case (mode)
          0: addr_text[idx] = alpha((value_of(addr_text[idx]) + $urandom_range(1, 31)) % 32);
          1: addr_text[idx] = ($urandom_range(0, 1) == 0) ?
                              NOT_IN_SET[8 * $urandom_range(0, 3) +: 8] :
                              8'($urandom_range(0, 255));
          2: begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) addr_text.pop_back();
          end
          default: addr_text[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        endcase
      end
      AK_NOISE: begin
        addr_text = {};
        if ($urandom_range(0, 1) == 0) begin
          addr_text.push_back("b");
          addr_text.push_back("c");
          addr_text.push_back("1");
        end
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) addr_text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        // base58 lead char, tail ignored, sometimes past the char limit
        addr_text = {};
        addr_text.push_back(($urandom_range(0, 1) == 0) ? 8'("1") : 8'("3"));
        n = ($urandom_range(0, 9) == 0) ? 140 : $urandom_range(0, 30);
        for (k = 0; k < n; k++) addr_text.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // case folding: all upper, mixed, or lower
    mode = $urandom_range(0, 9);
    for (k = 0; k < addr_text.size(); k++) begin
      if (addr_text[k] >= "a" && addr_text[k] <= "z" &&
          (mode == 0 || (mode <= 2 && $urandom_range(0, 2) == 0)))
        addr_text[k] = addr_text[k] - 8'd32;
    end
  endfunction

  function automatic addr_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) return AK_WPKH;
    if (r < 32) return AK_WSH;
    if (r < 46) return AK_TR;
    if (r < 56) return AK_ODD_VER;
    if (r < 68) return AK_RAW;
    if (r < 82) return AK_BROKEN;
    if (r < 93) return AK_NOISE;
    return AK_BASE58;
  endfunction

  // one char beat: optional idle burst, offer, wait for the handshake, predict
  task automatic put_char(input logic [7:0] c, input logic fin, input logic typed,
                          input logic [1:0] code);
    int gap;
    int k;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    addr_char <= c;
    is_last <= fin;
    do @(posedge clk); while (!char_ready);
    chars_sent++;
    if (d_pos < ADDR_CHAR_LIMIT && d_err != b32s_pkg::STATUS_BASE58) live_chars++;
    absorb_char(c);
    if (fin) begin
      close_address();
      // directed rows carry their error beat typed in
      if (typed) begin
        fresh_beats = {};
        fresh_beats.push_back('{8'd0, 6'd0, code, 1'b1});
      end
      for (k = 0; k < fresh_beats.size(); k++) scripts_due.push_back(fresh_beats[k]);
      addresses++;
    end
  endtask

  task automatic send_address();
    int k;
    for (k = 0; k < addr_text.size(); k++)
      put_char(addr_text[k], (k == addr_text.size() - 1), 1'b0, b32s_pkg::STATUS_OK);
  endtask

  // capacity writes only with the core idle and nothing owed
  task automatic set_capacity(input logic [7:0] v);
    @(negedge clk);
    char_valid <= 1'b0;
    while (scripts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    d_cap = v;
    cap_writes++;
  endtask

  // script side: random stall bursts, one long hold on request
  initial begin : rx_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        byte_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES - 1;
        held_cycles = held_cycles + HOLD_CYCLES;
        byte_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        byte_ready <= 1'b0;
      end else begin
        byte_ready <= 1'b1;
      end
    end
  end

  // every script beat against the oldest one owed
  always @(posedge clk) begin : beat_check
    script_beat_t want;
    logic bad;
    if (!rst && byte_valid && byte_ready) begin
      beats_checked++;
      if (scripts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat byte %02h len %0d status %0d last %0d", $time,
                   script_byte, script_length, status, last_byte);
      end else begin
        want = scripts_due.pop_front();
        bad = (script_byte !== want.data) || (script_length !== want.length) ||
              (status !== want.code) || (last_byte !== want.tail);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: beat mismatch want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d", $time,
                     want.data, want.length, want.code, want.tail,
                     script_byte, script_length, status, last_byte);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (byte_valid && byte_ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d beats still owed", quiet,
                 scripts_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stim
    int ph, k;
    clear_decoder();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows at the reset capacity
    for (k = 0; k < 23; k++) put_char(dir_tab[k].ch, dir_tab[k].fin, 1'b1, dir_tab[k].code);

    // long receiver hold over a full 34-byte burst while the next address is offered
    set_capacity(CAP_PLAN[0]);
    make_address(AK_TR);
    send_address();
    hold_req = 1'b1;
    make_address(AK_NOISE);
    send_address();

    // random addresses, each under its own capacity, until the char budget is spent
    ph = 1;
    while (chars_sent < RAND_BUDGET) begin
      set_capacity(CAP_PLAN[ph % N_PLAN]);
      do begin
        make_address(pick_kind());
      end while (chars_sent + addr_text.size() > RAND_BUDGET + BUDGET_SLACK);
      send_address();
      ph++;
    end

    // closing stretch at full rate on both sides
    calm = 1'b1;
    set_capacity(b32s_pkg::CAP_RESET);
    make_address(AK_WPKH);
    send_address();

    @(negedge clk);
    char_valid <= 1'b0;
    while (scripts_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (scripts_due.size() != 0) mismatches++;

    $display("covered %0d chars (%0d decoded) in %0d addresses, %0d capacity settings",
             chars_sent, live_chars, addresses, cap_writes);
    $display("scripts 22B %0d, 34B %0d, invalid %0d, base58 %0d; %0d beats, %0d-cycle hold",
             n_wpkh, n_wide, n_bad, n_b58, beats_checked, held_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
